// ===== src/bds_pkg.sv =====
// bds_pkg: field widths, store entry type and register indexes shared by
// the depth sorter top level and its squared-distance unit. No dependencies.
package bds_pkg;

  localparam int ID_W   = 16;
  localparam int POS_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int ACC_W  = SQ_W + 1;
  localparam int DIST_W = 36;
  localparam int CIDX_W = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_EYE_X = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_EYE_Y = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_EYE_Z = 2'd2;

  // one stored record: id and squared distance
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
  } entry_t;

endpackage

// ===== src/bds_sqdist.sv =====
// bds_sqdist: squared distance between a position and the eye point, one
// shared 17x17 multiplier used once per axis. Depends on bds_pkg.
module bds_sqdist import bds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [POS_W-1:0]  eye_x,
  input  logic signed [POS_W-1:0]  eye_y,
  input  logic signed [POS_W-1:0]  eye_z,
  output logic                     done,
  output logic [DIST_W-1:0]        sum_sq
);

  logic                      active;
  logic [1:0]                axis;
  logic signed [DIFF_W-1:0]  diff_x;
  logic signed [DIFF_W-1:0]  diff_y;
  logic signed [DIFF_W-1:0]  diff_z;
  logic signed [DIFF_W-1:0]  diff_sel;
  logic signed [SQ_W-1:0]    sq;
  logic [SQ_W-1:0]           prod;
  logic [ACC_W-1:0]          acc;

  // operand select for the shared multiplier
  always_comb begin
    case (axis)
      2'd0:    diff_sel = diff_x;
      2'd1:    diff_sel = diff_y;
      default: diff_sel = diff_z;
    endcase
  end

  assign sq = diff_sel * diff_sel;

  // sequencer: one axis per cycle, product registered, then summed
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      axis   <= 2'd0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        axis   <= 2'd0;
      end else if (active) begin
        axis <= axis + 2'd1;
        if (axis == 2'd3) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // datapath: differences latched at go, then multiply and accumulate
  always_ff @(posedge clk) begin
    if (go) begin
      diff_x <= DIFF_W'(pos_x) - DIFF_W'(eye_x);
      diff_y <= DIFF_W'(pos_y) - DIFF_W'(eye_y);
      diff_z <= DIFF_W'(pos_z) - DIFF_W'(eye_z);
    end else if (active) begin
      if (axis != 2'd3) begin
        prod <= $unsigned(sq);
      end
      case (axis)
        2'd0:    acc <= '0;
        2'd1:    acc <= ACC_W'(prod);
        2'd2:    acc <= acc + ACC_W'(prod);
        default: sum_sq <= DIST_W'(acc + ACC_W'(prod));
      endcase
    end
  end

endmodule

// ===== src/back_to_front_depth_sorter.sv =====
// back_to_front_depth_sorter: collects transparent records of a frame, keeps
// them sorted farthest first, emits them on the frame's last record.
// Depends on bds_pkg and bds_sqdist.
//
//  channel   handshake               payload
//  input     start / busy            object_id pos_x pos_y pos_z
//                                    is_transparent frame_end
//  result    result_strobe           sorted_id distance_sq last_result
//                                    empty_frame overflowed
//  config    cfg_valid / cfg_ready   cfg_index cfg_data
//
// A record that is not stored is taken without leaving idle unless it ends the
// frame. A stored record first waits on the squared-distance unit (three
// products on the shared multiplier, a final sum, then the done beat), then is
// inserted into the store, which moves each nearer entry down (read, then
// compare and write) and places the record at the head or behind a
// farther-or-equal entry. On frame_end the burst makes one store read per
// result.
// rst is synchronous; it clears the eye registers, count and overflow flag.
// Results cannot be stalled; busy stays high until the last read is issued.
module back_to_front_depth_sorter import bds_pkg::*; #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ID_W-1:0]          object_id,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic                     is_transparent,
  input  logic                     frame_end,
  output logic                     result_strobe,
  output logic [ID_W-1:0]          sorted_id,
  output logic [DIST_W-1:0]        distance_sq,
  output logic                     last_result,
  output logic                     empty_frame,
  output logic                     overflowed,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [POS_W-1:0]         cfg_data
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIST    = 3'd1;
  localparam logic [2:0] S_INS_RD  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]               state;
  logic [CW-1:0]            count;
  logic                     overflow;
  logic                     pend_end;
  logic [AW-1:0]            slot;
  logic [CW-1:0]            emit_idx;
  logic [ID_W-1:0]          new_id;
  logic [DIST_W-1:0]        new_dist;
  logic signed [POS_W-1:0]  eye_x;
  logic signed [POS_W-1:0]  eye_y;
  logic signed [POS_W-1:0]  eye_z;

  entry_t                   mem [MAX_ITEMS];
  logic [AW-1:0]            rd_addr;
  entry_t                   rd_data;
  logic                     wr_en;
  entry_t                   wr_data;

  logic                     out_strobe;
  logic                     out_last;
  logic                     out_empty;
  logic                     out_ovf;

  logic                     accept;
  logic                     has_room;
  logic                     dist_go;
  logic                     dist_done;
  logic [DIST_W-1:0]        dist_val;
  logic                     shift_down;
  logic                     emit_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign has_room  = (count < CW'(MAX_ITEMS));
  assign dist_go   = accept && is_transparent && has_room;
  assign shift_down = (rd_data.dsq < new_dist);
  assign emit_last = (emit_idx == CW'(count - 1'b1));

  // shared squared-distance unit
  bds_sqdist u_sqdist (
    .clk    (clk),
    .rst    (rst),
    .go     (dist_go),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .pos_z  (pos_z),
    .eye_x  (eye_x),
    .eye_y  (eye_y),
    .eye_z  (eye_z),
    .done   (dist_done),
    .sum_sq (dist_val)
  );

  // eye registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x <= '0;
      eye_y <= '0;
      eye_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EYE_X: eye_x <= cfg_data;
        CFG_EYE_Y: eye_y <= cfg_data;
        CFG_EYE_Z: eye_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // store read address and write port select
  always_comb begin
    case (state)
      S_INS_RD: rd_addr = slot - 1'b1;
      S_EMIT:   rd_addr = emit_idx[AW-1:0];
      default:  rd_addr = slot;
    endcase
    wr_en   = 1'b0;
    wr_data = '{id: new_id, dsq: new_dist};
    if (state == S_INS_RD && slot == '0) begin
      wr_en = 1'b1;
    end else if (state == S_INS_CMP) begin
      wr_en = 1'b1;
      if (shift_down) begin
        wr_data = rd_data;
      end
    end
  end

  // record store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer: load, insert in place, then emit the burst
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      overflow   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            new_id   <= object_id;
            pend_end <= frame_end;
            emit_idx <= '0;
            if (is_transparent && has_room) begin
              state <= S_DIST;
            end else begin
              if (is_transparent) begin
                overflow <= 1'b1;
              end
              if (frame_end) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_DIST: begin
          if (dist_done) begin
            new_dist <= dist_val;
            slot     <= count[AW-1:0];
            state    <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (slot == '0) begin
            count <= count + 1'b1;
            state <= pend_end ? S_EMIT : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (shift_down) begin
            slot  <= slot - 1'b1;
            state <= S_INS_RD;
          end else begin
            count <= count + 1'b1;
            state <= pend_end ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          out_strobe <= 1'b1;
          if (count == '0) begin
            out_empty <= 1'b1;
            out_last  <= 1'b1;
            out_ovf   <= 1'b0;
            overflow  <= 1'b0;
            state     <= S_IDLE;
          end else begin
            out_empty <= 1'b0;
            out_last  <= emit_last;
            out_ovf   <= overflow;
            emit_idx  <= emit_idx + 1'b1;
            if (emit_last) begin
              count    <= '0;
              overflow <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result beat, store read data lines up with the strobe
  assign result_strobe = out_strobe;
  assign sorted_id     = out_empty ? '0 : rd_data.id;
  assign distance_sq   = out_empty ? '0 : rd_data.dsq;
  assign last_result   = out_last;
  assign empty_frame   = out_empty;
  assign overflowed    = out_ovf;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("stored count beyond capacity");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && empty_frame |-> last_result && !overflowed)
    else $error("empty result not a lone last beat");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_result |=> result_strobe)
    else $error("gap inside result burst");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_result |=> !result_strobe)
    else $error("beat right after last result");

endmodule
